// File: rtl/ohpp_pkg.sv
package ohpp_pkg;

  // Histogram geometry
  localparam int BIN_COUNT   = 36;
  localparam int MAG_BITS    = 16;
  localparam int ACC_BITS    = 40;

  // Field widths on the stream ports
  localparam int MAG_IN_BITS = 16;
  localparam int DIR_BITS    = 15;
  localparam int DEG_BITS    = 9;
  localparam int IN_TDATA_BITS  = ((MAG_IN_BITS + DIR_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((DEG_BITS + 7) / 8) * 8;

  // Q9.6 degrees: 23040 is a full turn
  localparam int FULL_TURN  = 23040;
  localparam int BIN_WIDTH  = FULL_TURN / BIN_COUNT;
  localparam int HALF_WIDTH = BIN_WIDTH / 2;

  // Derived widths
  localparam int IDX_BITS   = $clog2(BIN_COUNT);
  localparam int Q_BITS     = IDX_BITS + 1;
  localparam int WGT_BITS   = $clog2(BIN_WIDTH + 1);
  localparam int REM_BITS   = WGT_BITS + 1;
  localparam int X_BITS     = DIR_BITS + 1;
  localparam int WPROD_BITS = MAG_BITS + WGT_BITS;
  localparam int SUM_BITS   = ((ACC_BITS > WPROD_BITS) ? ACC_BITS : WPROD_BITS) + 1;

  // Reciprocal of the bin width for the direction-to-bin divide
  localparam int RECIP_SHIFT = 32;
  localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / BIN_WIDTH;
  localparam int RECIP_BITS  = $clog2(RECIP + 1);
  localparam int PROD_W      = ((X_BITS + RECIP_BITS) > (RECIP_SHIFT + Q_BITS)) ?
                               (X_BITS + RECIP_BITS) : (RECIP_SHIFT + Q_BITS);

  localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};

  // Sequencer states
  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_WAIT,
    ST_SCAN
  } hist_state_t;

  // One sample mapped to its two bins and weights
  typedef struct packed {
    logic                vld;
    logic [IDX_BITS-1:0] own;
    logic [IDX_BITS-1:0] oth;
    logic [WGT_BITS-1:0] w_own;
    logic [WGT_BITS-1:0] w_oth;
    logic [MAG_BITS-1:0] mag;
  } bin_item_t;

  // Scan request from the sequencer
  typedef struct packed {
    logic                en;
    logic                first;
    logic                last;
    logic [IDX_BITS-1:0] addr;
  } scan_req_t;

  // One bin total coming out of the scan
  typedef struct packed {
    logic                vld;
    logic                first;
    logic                last;
    logic [IDX_BITS-1:0] idx;
    logic [ACC_BITS-1:0] value;
  } scan_elem_t;

  // Bin index to whole degrees
  typedef logic [DEG_BITS-1:0] deg_tab_t [BIN_COUNT];

  function automatic deg_tab_t build_deg_tab();
    deg_tab_t t;
    for (int i = 0; i < BIN_COUNT; i++) begin
      t[i] = DEG_BITS'((i * 360) / BIN_COUNT);
    end
    return t;
  endfunction

endpackage

// File: rtl/ohpp_bin_map.sv
module ohpp_bin_map (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [ohpp_pkg::MAG_IN_BITS-1:0]    in_mag,
  input  logic [ohpp_pkg::DIR_BITS-1:0]       in_dir,
  output ohpp_pkg::bin_item_t                 item,
  output logic                                busy
);
  import ohpp_pkg::*;

  logic                s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic [X_BITS-1:0]   s1_x_r, s2_x_r;
  logic [MAG_BITS-1:0] s1_mag_r, s2_mag_r, s3_mag_r, s4_mag_r;
  logic [PROD_W-1:0]   s2_prod_r;
  logic [Q_BITS-1:0]   s3_q0_r;
  logic [REM_BITS-1:0] s3_r0_r;
  logic [IDX_BITS-1:0] s4_own_r, s4_oth_r;
  logic [WGT_BITS-1:0] s4_wown_r, s4_woth_r;

  logic [X_BITS-1:0]   x_nxt;
  logic [PROD_W-1:0]   prod_nxt;
  logic [Q_BITS-1:0]   q0_nxt;
  logic [REM_BITS-1:0] r0_nxt;
  logic                corr;
  logic [WGT_BITS-1:0] rem;
  logic [Q_BITS-1:0]   q;
  logic [IDX_BITS-1:0] own_nxt, oth_nxt;

  // Rounded bin: (phi + W/2) / W by reciprocal multiply and one correction
  always_comb begin
    x_nxt    = X_BITS'(in_dir) + X_BITS'(HALF_WIDTH);
    prod_nxt = PROD_W'(s1_x_r) * PROD_W'(RECIP);
    q0_nxt   = s2_prod_r[RECIP_SHIFT +: Q_BITS];
    r0_nxt   = REM_BITS'(s2_x_r - X_BITS'(q0_nxt * BIN_WIDTH));
  end

  // Correct quotient, wrap bin index, neighbor is always the bin below
  always_comb begin
    corr    = (s3_r0_r >= REM_BITS'(BIN_WIDTH));
    rem     = corr ? WGT_BITS'(s3_r0_r - REM_BITS'(BIN_WIDTH)) : WGT_BITS'(s3_r0_r);
    q       = s3_q0_r + Q_BITS'(corr);
    own_nxt = (q >= Q_BITS'(BIN_COUNT)) ? IDX_BITS'(q - Q_BITS'(BIN_COUNT)) : IDX_BITS'(q);
    oth_nxt = (own_nxt == '0) ? IDX_BITS'(BIN_COUNT - 1) : own_nxt - 1'b1;
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    s1_x_r    <= x_nxt;
    s1_mag_r  <= MAG_BITS'(in_mag);
    s2_x_r    <= s1_x_r;
    s2_mag_r  <= s1_mag_r;
    s2_prod_r <= prod_nxt;
    s3_q0_r   <= q0_nxt;
    s3_r0_r   <= r0_nxt;
    s3_mag_r  <= s2_mag_r;
    s4_own_r  <= own_nxt;
    s4_oth_r  <= oth_nxt;
    s4_wown_r <= rem;
    s4_woth_r <= WGT_BITS'(BIN_WIDTH) - rem;
    s4_mag_r  <= s3_mag_r;
  end

  assign item.vld   = s4_vld_r;
  assign item.own   = s4_own_r;
  assign item.oth   = s4_oth_r;
  assign item.w_own = s4_wown_r;
  assign item.w_oth = s4_woth_r;
  assign item.mag   = s4_mag_r;

  assign busy = s1_vld_r | s2_vld_r | s3_vld_r | s4_vld_r;

endmodule

// File: rtl/ohpp_hist.sv
module ohpp_hist (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ohpp_pkg::bin_item_t    item,
  input  ohpp_pkg::scan_req_t    scan,
  output ohpp_pkg::scan_elem_t   elem,
  output logic                   busy
);
  import ohpp_pkg::*;

  // Own-bin and neighbor-bin shares kept apart; total is their saturated sum
  logic [ACC_BITS-1:0]  mem_own [BIN_COUNT];
  logic [ACC_BITS-1:0]  mem_oth [BIN_COUNT];
  logic [BIN_COUNT-1:0] vld_own_r, vld_oth_r;

  logic [IDX_BITS-1:0]  rd_addr_own, rd_addr_oth;
  logic [ACC_BITS-1:0]  rd_own_r, rd_oth_r;
  logic                 rd_own_vld_r, rd_oth_vld_r;

  // Accumulate stage
  logic                  acc_vld_r;
  logic [IDX_BITS-1:0]   acc_own_r, acc_oth_r;
  logic [WPROD_BITS-1:0] acc_wown_r, acc_woth_r;

  // Last write, for read-after-write forwarding
  logic                  fwd_own_vld_r, fwd_oth_vld_r;
  logic [IDX_BITS-1:0]   fwd_own_addr_r, fwd_oth_addr_r;
  logic [ACC_BITS-1:0]   fwd_own_data_r, fwd_oth_data_r;

  // Scan stage
  logic                  sc_vld_r, sc_first_r, sc_last_r;
  logic [IDX_BITS-1:0]   sc_idx_r;
  logic                  el_vld_r, el_first_r, el_last_r;
  logic [IDX_BITS-1:0]   el_idx_r;
  logic [ACC_BITS-1:0]   el_value_r;

  logic [ACC_BITS-1:0]   cur_own, cur_oth, new_own, new_oth, tot_nxt;
  logic [SUM_BITS-1:0]   sum_own, sum_oth;
  logic [ACC_BITS:0]     sum_tot;

  assign rd_addr_own = scan.en ? scan.addr : item.own;
  assign rd_addr_oth = scan.en ? scan.addr : item.oth;

  // Read-modify-write with saturation
  always_comb begin
    if (fwd_own_vld_r && (fwd_own_addr_r == acc_own_r)) begin
      cur_own = fwd_own_data_r;
    end else begin
      cur_own = rd_own_vld_r ? rd_own_r : '0;
    end
    if (fwd_oth_vld_r && (fwd_oth_addr_r == acc_oth_r)) begin
      cur_oth = fwd_oth_data_r;
    end else begin
      cur_oth = rd_oth_vld_r ? rd_oth_r : '0;
    end
    sum_own = SUM_BITS'(cur_own) + SUM_BITS'(acc_wown_r);
    sum_oth = SUM_BITS'(cur_oth) + SUM_BITS'(acc_woth_r);
    new_own = (sum_own >= SUM_BITS'(ACC_MAX)) ? ACC_MAX : ACC_BITS'(sum_own);
    new_oth = (sum_oth >= SUM_BITS'(ACC_MAX)) ? ACC_MAX : ACC_BITS'(sum_oth);
  end

  // Scan total of both shares
  always_comb begin
    sum_tot = (ACC_BITS + 1)'(rd_own_vld_r ? rd_own_r : '0)
            + (ACC_BITS + 1)'(rd_oth_vld_r ? rd_oth_r : '0);
    tot_nxt = (sum_tot >= (ACC_BITS + 1)'(ACC_MAX)) ? ACC_MAX : ACC_BITS'(sum_tot);
  end

  // Memories: read-first, one write port each
  always_ff @(posedge clk) begin
    rd_own_r <= mem_own[rd_addr_own];
    rd_oth_r <= mem_oth[rd_addr_oth];
    if (acc_vld_r) begin
      mem_own[acc_own_r] <= new_own;
      mem_oth[acc_oth_r] <= new_oth;
    end
  end

  // Entry valid bits: set on accumulate, dropped as the scan reads them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_own_r     <= '0;
      vld_oth_r     <= '0;
      rd_own_vld_r  <= 1'b0;
      rd_oth_vld_r  <= 1'b0;
      acc_vld_r     <= 1'b0;
      fwd_own_vld_r <= 1'b0;
      fwd_oth_vld_r <= 1'b0;
      sc_vld_r      <= 1'b0;
      el_vld_r      <= 1'b0;
    end else begin
      rd_own_vld_r  <= vld_own_r[rd_addr_own];
      rd_oth_vld_r  <= vld_oth_r[rd_addr_oth];
      if (acc_vld_r) begin
        vld_own_r[acc_own_r] <= 1'b1;
        vld_oth_r[acc_oth_r] <= 1'b1;
      end
      if (scan.en) begin
        vld_own_r[scan.addr] <= 1'b0;
        vld_oth_r[scan.addr] <= 1'b0;
      end
      acc_vld_r     <= item.vld & ~scan.en;
      fwd_own_vld_r <= acc_vld_r;
      fwd_oth_vld_r <= acc_vld_r;
      sc_vld_r      <= scan.en;
      el_vld_r      <= sc_vld_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    acc_own_r      <= item.own;
    acc_oth_r      <= item.oth;
    acc_wown_r     <= WPROD_BITS'(item.mag) * WPROD_BITS'(item.w_own);
    acc_woth_r     <= WPROD_BITS'(item.mag) * WPROD_BITS'(item.w_oth);
    fwd_own_addr_r <= acc_own_r;
    fwd_oth_addr_r <= acc_oth_r;
    fwd_own_data_r <= new_own;
    fwd_oth_data_r <= new_oth;
    sc_idx_r       <= scan.addr;
    sc_first_r     <= scan.first;
    sc_last_r      <= scan.last;
    el_idx_r       <= sc_idx_r;
    el_first_r     <= sc_first_r;
    el_last_r      <= sc_last_r;
    el_value_r     <= tot_nxt;
  end

  assign elem.vld   = el_vld_r;
  assign elem.first = el_first_r;
  assign elem.last  = el_last_r;
  assign elem.idx   = el_idx_r;
  assign elem.value = el_value_r;

  assign busy = acc_vld_r | sc_vld_r | el_vld_r;

endmodule

// File: rtl/ohpp_peak.sv
module ohpp_peak (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ohpp_pkg::scan_elem_t            elem,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ohpp_pkg::DEG_BITS-1:0]   out_deg,
  output logic                            out_last,
  output logic                            busy
);
  import ohpp_pkg::*;

  localparam deg_tab_t DEG_TAB = build_deg_tab();

  logic [ACC_BITS-1:0] first_val_r, second_val_r;
  logic [IDX_BITS-1:0] first_idx_r, second_idx_r;
  logic                have_second_r;
  logic                decide_r;

  // Two-entry result queue
  logic [1:0]          cnt_r, cnt_nxt;
  logic [DEG_BITS-1:0] ent0_deg_r, ent1_deg_r, ent0_deg_nxt, ent1_deg_nxt;
  logic                ent0_last_r, ent1_last_r, ent0_last_nxt, ent1_last_nxt;

  logic [ACC_BITS+2:0] five_second, four_first;
  logic                emit2;

  // Second peak qualifies at 0.8 of the first
  always_comb begin
    five_second = {second_val_r, 2'b00} + (ACC_BITS + 3)'(second_val_r);
    four_first  = {1'b0, first_val_r, 2'b00};
    emit2       = have_second_r && (five_second >= four_first);
  end

  // Queue push after the decision, pop on output transaction
  always_comb begin
    cnt_nxt       = cnt_r;
    ent0_deg_nxt  = ent0_deg_r;
    ent0_last_nxt = ent0_last_r;
    ent1_deg_nxt  = ent1_deg_r;
    ent1_last_nxt = ent1_last_r;
    if (decide_r) begin
      ent0_deg_nxt  = DEG_TAB[first_idx_r];
      ent0_last_nxt = ~emit2;
      ent1_deg_nxt  = DEG_TAB[second_idx_r];
      ent1_last_nxt = 1'b1;
      cnt_nxt       = emit2 ? 2'd2 : 2'd1;
    end else if (out_valid && out_ready) begin
      ent0_deg_nxt  = ent1_deg_r;
      ent0_last_nxt = ent1_last_r;
      cnt_nxt       = cnt_r - 2'd1;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_second_r <= 1'b0;
      decide_r      <= 1'b0;
      cnt_r         <= 2'd0;
    end else begin
      decide_r <= elem.vld & elem.last;
      cnt_r    <= cnt_nxt;
      if (elem.vld) begin
        if (elem.first) begin
          have_second_r <= 1'b0;
        end else if ((elem.value > first_val_r) || !have_second_r ||
                     (elem.value > second_val_r)) begin
          have_second_r <= 1'b1;
        end
      end
    end
  end

  // Running top two, strict compare keeps the lower index on ties
  always_ff @(posedge clk) begin
    if (elem.vld) begin
      if (elem.first) begin
        first_val_r <= elem.value;
        first_idx_r <= elem.idx;
      end else if (elem.value > first_val_r) begin
        second_val_r <= first_val_r;
        second_idx_r <= first_idx_r;
        first_val_r  <= elem.value;
        first_idx_r  <= elem.idx;
      end else if (!have_second_r || (elem.value > second_val_r)) begin
        second_val_r <= elem.value;
        second_idx_r <= elem.idx;
      end
    end
    ent0_deg_r  <= ent0_deg_nxt;
    ent0_last_r <= ent0_last_nxt;
    ent1_deg_r  <= ent1_deg_nxt;
    ent1_last_r <= ent1_last_nxt;
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_deg   = ent0_deg_r;
  assign out_last  = ent0_last_r;
  assign busy      = decide_r | (cnt_r != 2'd0);

endmodule

// File: rtl/orientation_histogram_peak_pick.sv
// Throughput: one sample per cycle while a window accumulates.
// A last sample holds off the input until the scan is done: the four-stage
// bin map and the accumulate stage drain, one idle check, then one bin a cycle is read and cleared.
// The first orientation becomes valid after the last bin's total has left the scan.
// The scan also waits until the previous window's orientations have been taken.
// Reset (rst_n low, synchronous) empties the histogram, the pipeline and the result queue.
module orientation_histogram_peak_pick (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [15:0] sample_magnitude, [30:16] sample_direction, [31] zero
  input  logic [ohpp_pkg::IN_TDATA_BITS-1:0]   in_tdata,
  input  logic                                 in_tlast,  // last_sample
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [8:0] orientation_deg, [15:9] zero
  output logic [ohpp_pkg::OUT_TDATA_BITS-1:0]  out_tdata,
  output logic                                 out_tlast  // last_of_run
);
  import ohpp_pkg::*;

  hist_state_t         state_r, state_nxt;
  logic [IDX_BITS-1:0] scan_addr_r, scan_addr_nxt;
  scan_req_t           scan_req;
  bin_item_t           item;
  scan_elem_t          elem;
  logic                map_busy, hist_busy, peak_busy;
  logic                in_acc;
  logic [DEG_BITS-1:0] out_deg;

  assign in_acc = in_tvalid & in_tready;

  ohpp_bin_map u_bin_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_acc),
    .in_mag   (in_tdata[MAG_IN_BITS-1:0]),
    .in_dir   (in_tdata[MAG_IN_BITS +: DIR_BITS]),
    .item     (item),
    .busy     (map_busy)
  );

  ohpp_hist u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .scan  (scan_req),
    .elem  (elem),
    .busy  (hist_busy)
  );

  ohpp_peak u_peak (
    .clk       (clk),
    .rst_n     (rst_n),
    .elem      (elem),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_deg   (out_deg),
    .out_last  (out_tlast),
    .busy      (peak_busy)
  );

  assign out_tdata = OUT_TDATA_BITS'(out_deg);

  // Sequencer: accumulate, drain, then scan and clear the histogram
  always_comb begin
    state_nxt      = state_r;
    scan_addr_nxt  = scan_addr_r;
    in_tready      = 1'b0;
    scan_req       = '0;
    scan_req.addr  = scan_addr_r;
    case (state_r)
      ST_ACCUM: begin
        in_tready = 1'b1;
        if (in_tvalid && in_tlast) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!map_busy && !hist_busy && !peak_busy) begin
          state_nxt     = ST_SCAN;
          scan_addr_nxt = '0;
        end
      end
      ST_SCAN: begin
        scan_req.en    = 1'b1;
        scan_req.first = (scan_addr_r == '0);
        scan_req.last  = (scan_addr_r == IDX_BITS'(BIN_COUNT - 1));
        if (scan_req.last) begin
          state_nxt = ST_ACCUM;
        end else begin
          scan_addr_nxt = scan_addr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      scan_addr_r <= '0;
    end else begin
      state_r     <= state_nxt;
      scan_addr_r <= scan_addr_nxt;
    end
  end

endmodule
